/* rtl/rcph_pkg.sv */
// ----------------------------------------------------------------------------
// rcph_pkg
// Shared types, codes and helpers for the close/pass handshake block.
// ----------------------------------------------------------------------------
package rcph_pkg;

    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int CPORT_W  = 15;   // width of the port registers
    localparam int KIND_W   = 3;
    localparam int MODE_W   = 2;
    localparam int CODE_W   = 3;    // external phase code
    localparam int ERR_W    = 2;
    localparam int RETRY_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [RETRY_W-1:0] MAX_TRIES = 8'd5;

    // Event modes
    localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECV    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SOCKERR = 2'd3;

    // Message kinds
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSING = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CONFIRM = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READY   = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RETRY   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SOCKET  = 2'd2;

    // External phase codes
    localparam logic [CODE_W-1:0] PCODE_IDLE = 3'd0;
    localparam logic [CODE_W-1:0] PCODE_REQ  = 3'd1;
    localparam logic [CODE_W-1:0] PCODE_HOLD = 3'd2;
    localparam logic [CODE_W-1:0] PCODE_PASS = 3'd3;
    localparam logic [CODE_W-1:0] PCODE_DONE = 3'd4;
    localparam logic [CODE_W-1:0] PCODE_FAIL = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_ADDR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_PORT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_ADDR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_PORT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_EN   = 3'd4;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_REQ  = 6'b000010,
        PH_HOLD = 6'b000100,
        PH_PASS = 6'b001000,
        PH_DONE = 6'b010000,
        PH_FAIL = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  upstream_address;
        logic [CPORT_W-1:0] upstream_port;
        logic [ADDR_W-1:0]  next_address;
        logic [CPORT_W-1:0] pass_port;
        logic               pass_enabled;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [RETRY_W-1:0] retry_count;
        logic [ERR_W-1:0]   fail_reason;
    } state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KIND_W-1:0] message_kind;
        logic              empty_datagram;
        logic [ADDR_W-1:0] source_address;
        logic [PORT_W-1:0] source_port;
    } event_t;

    typedef struct packed {
        logic              send_valid;
        logic [KIND_W-1:0] send_kind;
        logic [ADDR_W-1:0] send_address;
        logic [PORT_W-1:0] send_port;
        logic [CODE_W-1:0] phase;
        logic [ERR_W-1:0]  error_code;
    } result_t;

    function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
        logic [CODE_W-1:0] code;
        case (ph)
            PH_IDLE: code = PCODE_IDLE;
            PH_REQ:  code = PCODE_REQ;
            PH_HOLD: code = PCODE_HOLD;
            PH_PASS: code = PCODE_PASS;
            PH_DONE: code = PCODE_DONE;
            PH_FAIL: code = PCODE_FAIL;
            default: code = PCODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

/* rtl/relay_close_pass_handshake.sv */
// ----------------------------------------------------------------------------
// relay_close_pass_handshake
// Close handshake with token passing over datagrams: one result per event.
// ----------------------------------------------------------------------------
// Each event request on the s_ side produces exactly one result request on the
// m_ side, the cycle after it is accepted. The block takes one event per cycle:
// the event is decoded against the phase and retry count in a single pass and
// lands in the result register. A new event is taken while the previous result
// is being taken, so the only stall is a full result register with m_tready
// low. The user must write registers through the cfg port only while no event
// is in flight, unenforced by the block; done and failed hold until reset.
module relay_close_pass_handshake (
    input  logic        clk,
    input  logic        rst_n,
    // event in
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] mode, [4:2] message_kind, [5] empty_datagram,
    // [37:6] source_address, [53:38] source_port, [55:54] zero
    input  logic [55:0] s_tdata,
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] send_valid, [3:1] send_kind, [35:4] send_address,
    // [51:36] send_port, [54:52] phase, [56:55] error_code, [63:57] zero
    output logic [63:0] m_tdata,
    // configuration
    input  logic                              cfg_we,
    input  logic [rcph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcph_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rcph_pkg::cfg_t    cfg_reg;
    rcph_pkg::state_t  state_reg;
    rcph_pkg::state_t  state_next;
    rcph_pkg::event_t  ev;
    rcph_pkg::result_t res;
    rcph_pkg::result_t out_q;
    logic              accept;

    assign ev.mode           = s_tdata[1:0];
    assign ev.message_kind   = s_tdata[4:2];
    assign ev.empty_datagram = s_tdata[5];
    assign ev.source_address = s_tdata[37:6];
    assign ev.source_port    = s_tdata[53:38];

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upstream_address <= '0;
            cfg_reg.upstream_port    <= 15'd1;
            cfg_reg.next_address     <= '0;
            cfg_reg.pass_port        <= 15'd1;
            cfg_reg.pass_enabled     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcph_pkg::REG_UP_ADDR:   cfg_reg.upstream_address <= cfg_data;
                rcph_pkg::REG_UP_PORT:   cfg_reg.upstream_port <= cfg_data[rcph_pkg::CPORT_W-1:0];
                rcph_pkg::REG_NEXT_ADDR: cfg_reg.next_address <= cfg_data;
                rcph_pkg::REG_NEXT_PORT: cfg_reg.pass_port <= cfg_data[rcph_pkg::CPORT_W-1:0];
                rcph_pkg::REG_PASS_EN:   cfg_reg.pass_enabled <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= rcph_pkg::PH_IDLE;
            state_reg.retry_count <= '0;
            state_reg.fail_reason <= rcph_pkg::ERR_NONE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    rcph_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .ev  (ev),
        .nxt (state_next),
        .res (res)
    );

    rcph_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .d     (res),
        .take  (m_tready),
        .ready (s_tready),
        .valid (m_tvalid),
        .q     (out_q)
    );

    assign m_tdata = {7'd0, out_q.error_code, out_q.phase, out_q.send_port,
                      out_q.send_address, out_q.send_kind, out_q.send_valid};

    // terminal phases never leave
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == rcph_pkg::PH_DONE |=> state_reg.phase == rcph_pkg::PH_DONE)
        else $error("done phase left");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == rcph_pkg::PH_FAIL |=> state_reg.phase == rcph_pkg::PH_FAIL)
        else $error("failed phase left");

    // retry counter never reaches the limit outside failure
    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != rcph_pkg::PH_FAIL |-> state_reg.retry_count < rcph_pkg::MAX_TRIES)
        else $error("retry count at limit without failure");

    // an error code is only reported together with the failed phase
    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_q.error_code != rcph_pkg::ERR_NONE |-> out_q.phase == rcph_pkg::PCODE_FAIL)
        else $error("error code outside failed phase");

    // the result register reflects the state updated by the same request
    a_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_q.phase == rcph_pkg::phase_code(state_reg.phase))
        else $error("result phase differs from state");

endmodule

/* rtl/rcph_step.sv */
// ----------------------------------------------------------------------------
// rcph_step
// Next-state and reply logic for one event, purely combinational.
// ----------------------------------------------------------------------------
module rcph_step (
    input  rcph_pkg::cfg_t    cfg,
    input  rcph_pkg::state_t  cur,
    input  rcph_pkg::event_t  ev,
    output rcph_pkg::state_t  nxt,
    output rcph_pkg::result_t res
);

    logic                              has_msg;
    logic                              from_up;
    logic                              from_next;
    logic [rcph_pkg::RETRY_W-1:0]      retry_inc;
    logic                              retry_hit;
    logic                              tx_valid;
    logic [rcph_pkg::KIND_W-1:0]       tx_kind;
    logic [rcph_pkg::ADDR_W-1:0]       tx_addr;
    logic [rcph_pkg::PORT_W-1:0]       tx_port;
    logic [rcph_pkg::PORT_W-1:0]       up_port;
    logic [rcph_pkg::PORT_W-1:0]       nx_port;

    assign up_port   = {1'b0, cfg.upstream_port};
    assign nx_port   = {1'b0, cfg.pass_port};
    assign has_msg   = (ev.mode == rcph_pkg::MODE_RECV) && !ev.empty_datagram;
    assign from_up   = (ev.source_address == cfg.upstream_address) && (ev.source_port == up_port);
    assign from_next = (ev.source_address == cfg.next_address) && (ev.source_port == nx_port);
    assign retry_inc = cur.retry_count + 1'b1;
    assign retry_hit = retry_inc >= rcph_pkg::MAX_TRIES;

    always_comb
    begin
        nxt      = cur;
        tx_valid = 1'b0;
        tx_kind  = '0;
        tx_addr  = '0;
        tx_port  = '0;

        case (cur.phase)
            rcph_pkg::PH_IDLE:
            begin
                if (ev.mode == rcph_pkg::MODE_START)
                begin
                    nxt.phase       = rcph_pkg::PH_REQ;
                    nxt.retry_count = '0;
                    tx_valid = 1'b1;
                    tx_kind  = rcph_pkg::KIND_CLOSE;
                    tx_addr  = cfg.upstream_address;
                    tx_port  = up_port;
                end
            end
            rcph_pkg::PH_REQ:
            begin
                if (ev.mode == rcph_pkg::MODE_SOCKERR)
                begin
                    nxt.phase       = rcph_pkg::PH_FAIL;
                    nxt.fail_reason = rcph_pkg::ERR_SOCKET;
                end
                else if (ev.mode == rcph_pkg::MODE_TIMEOUT)
                begin
                    nxt.retry_count = retry_inc;
                    if (retry_hit)
                    begin
                        nxt.phase       = rcph_pkg::PH_FAIL;
                        nxt.fail_reason = rcph_pkg::ERR_RETRY;
                    end
                    else
                    begin
                        tx_valid = 1'b1;
                        tx_kind  = rcph_pkg::KIND_CLOSE;
                        tx_addr  = cfg.upstream_address;
                        tx_port  = up_port;
                    end
                end
                else if (ev.mode == rcph_pkg::MODE_RECV)
                begin
                    nxt.retry_count = '0;
                    tx_valid = 1'b1;
                    if (has_msg && ev.message_kind == rcph_pkg::KIND_CLOSING && from_up)
                    begin
                        nxt.phase = rcph_pkg::PH_HOLD;
                        tx_kind   = rcph_pkg::KIND_CONFIRM;
                        tx_addr   = ev.source_address;
                        tx_port   = ev.source_port;
                    end
                    else
                    begin
                        tx_kind = rcph_pkg::KIND_CLOSE;
                        tx_addr = cfg.upstream_address;
                        tx_port = up_port;
                    end
                end
            end
            rcph_pkg::PH_HOLD:
            begin
                if (ev.mode == rcph_pkg::MODE_SOCKERR)
                begin
                    nxt.phase       = rcph_pkg::PH_FAIL;
                    nxt.fail_reason = rcph_pkg::ERR_SOCKET;
                end
                else if (has_msg)
                begin
                    if (ev.message_kind == rcph_pkg::KIND_FIND)
                    begin
                        tx_valid = 1'b1;
                        tx_kind  = rcph_pkg::KIND_READY;
                        tx_addr  = ev.source_address;
                        tx_port  = ev.source_port;
                    end
                    else if (ev.message_kind == rcph_pkg::KIND_CLOSING && from_up)
                    begin
                        tx_valid = 1'b1;
                        tx_kind  = rcph_pkg::KIND_CONFIRM;
                        tx_addr  = ev.source_address;
                        tx_port  = ev.source_port;
                    end
                    else if (ev.message_kind == rcph_pkg::KIND_CLOSE && cfg.pass_enabled
                             && from_next)
                    begin
                        nxt.phase       = rcph_pkg::PH_PASS;
                        nxt.retry_count = '0;
                        tx_valid = 1'b1;
                        tx_kind  = rcph_pkg::KIND_CLOSING;
                        tx_addr  = cfg.next_address;
                        tx_port  = nx_port;
                    end
                end
            end
            rcph_pkg::PH_PASS:
            begin
                if (ev.mode == rcph_pkg::MODE_SOCKERR)
                begin
                    nxt.phase       = rcph_pkg::PH_FAIL;
                    nxt.fail_reason = rcph_pkg::ERR_SOCKET;
                end
                else if (ev.mode == rcph_pkg::MODE_TIMEOUT)
                begin
                    nxt.retry_count = retry_inc;
                    if (retry_hit)
                    begin
                        nxt.phase       = rcph_pkg::PH_FAIL;
                        nxt.fail_reason = rcph_pkg::ERR_RETRY;
                    end
                    else
                    begin
                        tx_valid = 1'b1;
                        tx_kind  = rcph_pkg::KIND_CLOSING;
                        tx_addr  = cfg.next_address;
                        tx_port  = nx_port;
                    end
                end
                else if (ev.mode == rcph_pkg::MODE_RECV)
                begin
                    nxt.retry_count = '0;
                    if (has_msg && ev.message_kind == rcph_pkg::KIND_CONFIRM && from_next)
                    begin
                        nxt.phase = rcph_pkg::PH_DONE;
                    end
                    else
                    begin
                        tx_valid = 1'b1;
                        tx_kind  = rcph_pkg::KIND_CLOSING;
                        tx_addr  = cfg.next_address;
                        tx_port  = nx_port;
                    end
                end
            end
            default:
            begin
                // done and failed are terminal
            end
        endcase
    end

    always_comb
    begin
        res.send_valid   = tx_valid;
        res.send_kind    = tx_kind;
        res.send_address = tx_addr;
        res.send_port    = tx_port;
        res.phase        = rcph_pkg::phase_code(nxt.phase);
        res.error_code   = (nxt.phase == rcph_pkg::PH_FAIL) ? nxt.fail_reason
                                                            : rcph_pkg::ERR_NONE;
    end

endmodule

/* rtl/rcph_out_reg.sv */
// ----------------------------------------------------------------------------
// rcph_out_reg
// Result register with valid flag; takes a new result when empty or as the held one is taken.
// ----------------------------------------------------------------------------
module rcph_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rcph_pkg::result_t d,
    input  logic              take,
    output logic              ready,
    output logic              valid,
    output rcph_pkg::result_t q
);

    logic              valid_reg;
    logic              valid_next;
    rcph_pkg::result_t data_reg;

    assign ready      = !valid_reg || take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= d;
        end
    end

    assign valid = valid_reg;
    assign q     = data_reg;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives event requests into the close/pass handshake block and checks every
// result request against an in-bench prediction of phase, retries and replies.
// Runs through idle, requesting, holding and passing with random idling on
// both sides, then ends in one terminal phase picked at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rcph_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_GAP     = 18;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [55:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted state and register copies
    logic [CODE_W-1:0]  ph_now     = PCODE_IDLE;
    logic [RETRY_W-1:0] tries      = '0;
    logic [ERR_W-1:0]   why_failed = ERR_NONE;
    logic [ADDR_W-1:0]  up_addr    = '0;
    logic [CPORT_W-1:0] up_port    = 15'd1;
    logic [ADDR_W-1:0]  nx_addr    = '0;
    logic [CPORT_W-1:0] nx_port    = 15'd1;
    logic               pass_on    = 1'b0;

    result_t     pending_replies[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned calm_left[2]   = '{0, 0};

    relay_close_pass_handshake u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic bit peer_match(input event_t ev, input logic [ADDR_W-1:0] a,
                                      input logic [CPORT_W-1:0] p);
        return ev.source_address == a && ev.source_port == {1'b0, p};
    endfunction

    function automatic result_t outgoing(input logic [KIND_W-1:0] kind,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [PORT_W-1:0] port);
        result_t r;
        r = '0;
        r.send_valid   = 1'b1;
        r.send_kind    = kind;
        r.send_address = addr;
        r.send_port    = port;
        return r;
    endfunction

    function automatic result_t advance_handshake(input event_t ev);
        result_t r;
        logic    has_msg;
        logic    from_up;
        logic    from_next;
        r         = '0;
        has_msg   = ev.mode == MODE_RECV && !ev.empty_datagram;
        from_up   = peer_match(ev, up_addr, up_port);
        from_next = peer_match(ev, nx_addr, nx_port);
        case (ph_now)
            PCODE_IDLE:
            begin
                if (ev.mode == MODE_START)
                begin
                    ph_now = PCODE_REQ;
                    tries  = '0;
                    r = outgoing(KIND_CLOSE, up_addr, {1'b0, up_port});
                end
            end
            PCODE_REQ, PCODE_PASS:
            begin
                if (ev.mode == MODE_SOCKERR)
                begin
                    ph_now     = PCODE_FAIL;
                    why_failed = ERR_SOCKET;
                end
                else if (ev.mode == MODE_TIMEOUT)
                begin
                    tries = tries + 8'd1;
                    if (tries >= MAX_TRIES)
                    begin
                        ph_now     = PCODE_FAIL;
                        why_failed = ERR_RETRY;
                    end
                    else if (ph_now == PCODE_REQ)
                        r = outgoing(KIND_CLOSE, up_addr, {1'b0, up_port});
                    else
                        r = outgoing(KIND_CLOSING, nx_addr, {1'b0, nx_port});
                end
                else if (ev.mode == MODE_RECV)
                begin
                    // any datagram, even an empty one, clears the retry count
                    tries = '0;
                    if (ph_now == PCODE_REQ)
                    begin
                        if (has_msg && ev.message_kind == KIND_CLOSING && from_up)
                        begin
                            ph_now = PCODE_HOLD;
                            r = outgoing(KIND_CONFIRM, ev.source_address, ev.source_port);
                        end
                        else
                            r = outgoing(KIND_CLOSE, up_addr, {1'b0, up_port});
                    end
                    else if (has_msg && ev.message_kind == KIND_CONFIRM && from_next)
                        ph_now = PCODE_DONE;
                    else
                        r = outgoing(KIND_CLOSING, nx_addr, {1'b0, nx_port});
                end
            end
            PCODE_HOLD:
            begin
                if (ev.mode == MODE_SOCKERR)
                begin
                    ph_now     = PCODE_FAIL;
                    why_failed = ERR_SOCKET;
                end
                else if (has_msg)
                begin
                    if (ev.message_kind == KIND_FIND)
                        r = outgoing(KIND_READY, ev.source_address, ev.source_port);
                    else if (ev.message_kind == KIND_CLOSING && from_up)
                        r = outgoing(KIND_CONFIRM, ev.source_address, ev.source_port);
                    else if (ev.message_kind == KIND_CLOSE && pass_on && from_next)
                    begin
                        ph_now = PCODE_PASS;
                        tries  = '0;
                        r = outgoing(KIND_CLOSING, nx_addr, {1'b0, nx_port});
                    end
                end
            end
            default: ;
        endcase
        r.phase      = ph_now;
        r.error_code = (ph_now == PCODE_FAIL) ? why_failed : ERR_NONE;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned draw_gap(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left[side] = $urandom_range(8, 30);
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic event_t make_event(input logic [MODE_W-1:0] mode,
                                          input logic [KIND_W-1:0] kind,
                                          input logic empty,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [PORT_W-1:0] port);
        event_t ev;
        ev.mode           = mode;
        ev.message_kind   = kind;
        ev.empty_datagram = empty;
        ev.source_address = addr;
        ev.source_port    = port;
        return ev;
    endfunction

    // Random event aimed mostly at the configured peers; in requesting, holding and
    // passing, anything that would leave the phase is bent into a harmless event of it.
    function automatic event_t random_event();
        event_t      ev;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2:
            begin
                ev.source_address = up_addr;
                ev.source_port    = {1'b0, up_port};
            end
            3, 4, 5:
            begin
                ev.source_address = nx_addr;
                ev.source_port    = {1'b0, nx_port};
            end
            6:
            begin
                ev.source_address = up_addr;
                ev.source_port    = 16'($urandom_range(0, 65535));
            end
            7:
            begin
                ev.source_address = nx_addr;
                ev.source_port    = {1'b0, nx_port} ^ (16'd1 << $urandom_range(0, 15));
            end
            8:
            begin
                ev.source_address = $urandom;
                ev.source_port    = {1'b0, up_port};
            end
            default:
            begin
                ev.source_address = $urandom;
                ev.source_port    = 16'($urandom_range(0, 65535));
            end
        endcase
        ev.message_kind   = 3'($urandom_range(0, 7));
        ev.empty_datagram = ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 9);
        ev.mode = (pick == 0) ? MODE_START : (pick < 7) ? MODE_RECV : MODE_TIMEOUT;

        if (ev.mode == MODE_TIMEOUT && (ph_now == PCODE_REQ || ph_now == PCODE_PASS)
            && tries == MAX_TRIES - 8'd1)
            ev.mode = MODE_RECV;
        if (ev.mode == MODE_RECV && !ev.empty_datagram)
        begin
            if (ph_now == PCODE_REQ && ev.message_kind == KIND_CLOSING
                && peer_match(ev, up_addr, up_port))
                ev.message_kind = KIND_FIND;
            if (ph_now == PCODE_HOLD && ev.message_kind == KIND_CLOSE && pass_on
                && peer_match(ev, nx_addr, nx_port))
                ev.message_kind = KIND_READY;
            if (ph_now == PCODE_PASS && ev.message_kind == KIND_CONFIRM
                && peer_match(ev, nx_addr, nx_port))
                ev.message_kind = KIND_FIND;
        end
        return ev;
    endfunction

    task automatic send_event(input event_t ev);
        int unsigned gap;
        gap = draw_gap(0);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, ev.source_port, ev.source_address, ev.empty_datagram,
                    ev.message_kind, ev.mode};
        do @(posedge clk); while (s_tready !== 1'b1);
        pending_replies.push_back(advance_handshake(ev));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            REG_UP_ADDR:   up_addr = value;
            REG_UP_PORT:   up_port = value[CPORT_W-1:0];
            REG_NEXT_ADDR: nx_addr = value;
            REG_NEXT_PORT: nx_port = value[CPORT_W-1:0];
            REG_PASS_EN:   pass_on = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_peers(input logic [31:0] ua, input logic [31:0] up,
                             input logic [31:0] na, input logic [31:0] np,
                             input logic [31:0] pe);
        wait_drained();
        write_reg(REG_UP_ADDR, ua);
        write_reg(REG_UP_PORT, up);
        write_reg(REG_NEXT_ADDR, na);
        write_reg(REG_NEXT_PORT, np);
        write_reg(REG_PASS_EN, pe);
    endtask

    function automatic logic [31:0] any_port();
        return 32'($urandom_range(1, 25535));
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_replies.size() == 0)
                report_mismatch($sformatf("result %0h with no event pending", m_tdata));
            else
            begin
                want = pending_replies.pop_front();
                check_field("send_valid", 32'(m_tdata[0]), 32'(want.send_valid));
                check_field("send_kind", 32'(m_tdata[3:1]), 32'(want.send_kind));
                check_field("send_address", m_tdata[35:4], want.send_address);
                check_field("send_port", 32'(m_tdata[51:36]), 32'(want.send_port));
                check_field("phase", 32'(m_tdata[54:52]), 32'(want.phase));
                check_field("error_code", 32'(m_tdata[56:55]), 32'(want.error_code));
                check_field("padding", 32'(m_tdata[63:57]), 32'd0);
            end
        end
    end

    // result side: random back-pressure per result
    initial
    begin
        int unsigned gap;
        m_tready = 1'b0;
        forever
        begin
            gap = draw_gap(1);
            if (gap > 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_idle_ignored();
        send_event(make_event(MODE_RECV, 3'd7, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
        send_event(make_event(MODE_TIMEOUT, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
        send_event(make_event(MODE_SOCKERR, KIND_READY, 1'b0, 32'd0, 16'd1));
        send_event(make_event(MODE_RECV, KIND_CLOSING, 1'b0, 32'd0, 16'd1));
    endtask

    task automatic test_request_retries();
        set_peers(32'hFFFF_FFFF, 32'd25535, 32'd0, 32'd1, 32'd0);
        send_event(make_event(MODE_START, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
        // start while already requesting does nothing
        send_event(make_event(MODE_START, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
        repeat (MAX_TRIES - 1)
            send_event(make_event(MODE_TIMEOUT, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
        // empty datagram carries no message but still clears the count
        send_event(make_event(MODE_RECV, KIND_CLOSING, 1'b1, up_addr, {1'b0, up_port}));
        send_event(make_event(MODE_TIMEOUT, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
        send_event(make_event(MODE_RECV, KIND_CLOSING, 1'b0, up_addr,
                              {1'b1, up_port}));
        send_event(make_event(MODE_RECV, KIND_CLOSING, 1'b0, 32'd0, {1'b0, up_port}));
        send_event(make_event(MODE_RECV, 3'd7, 1'b0, up_addr, {1'b0, up_port}));
    endtask

    task automatic test_request_random();
        set_peers($urandom, any_port(), $urandom, any_port(), 32'd0);
        repeat (80) send_event(random_event());
        send_event(make_event(MODE_RECV, KIND_CLOSING, 1'b0, up_addr, {1'b0, up_port}));
    endtask

    task automatic test_hold_replies();
        // hold has no time limit
        send_event(make_event(MODE_TIMEOUT, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
        send_event(make_event(MODE_RECV, KIND_FIND, 1'b0, $urandom, 16'hFFFF));
        send_event(make_event(MODE_RECV, KIND_FIND, 1'b1, $urandom, 16'h0000));
        send_event(make_event(MODE_RECV, KIND_CLOSING, 1'b0, up_addr, {1'b0, up_port}));
        send_event(make_event(MODE_RECV, KIND_CLOSE, 1'b0, nx_addr, {1'b0, nx_port}));
        send_event(make_event(MODE_START, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
        send_event(make_event(MODE_RECV, 3'd6, 1'b0, up_addr, {1'b0, up_port}));
    endtask

    task automatic test_hold_random();
        for (int round = 0; round < 4; round++)
        begin
            case (round)
                0: set_peers($urandom, 32'd0, 32'hFFFF_FFFF, 32'd25535, 32'd0);
                // only the low fifteen bits of a port write are kept
                1: set_peers(32'd0, 32'hFFFF_FFFF, $urandom, 32'd1, 32'd1);
                2:
                begin
                    logic [31:0] a;
                    logic [31:0] p;
                    a = $urandom;
                    p = any_port();
                    set_peers(a, p, a, p, 32'd1);
                end
                default: set_peers($urandom, $urandom, $urandom, any_port(), 32'd0);
            endcase
            repeat (40) send_event(random_event());
        end
    endtask

    task automatic test_pass_retries();
        set_peers(up_addr, 32'(up_port), $urandom, any_port(), 32'd1);
        send_event(make_event(MODE_RECV, KIND_CLOSE, 1'b0, nx_addr, {1'b0, nx_port}));
        repeat (MAX_TRIES - 1)
            send_event(make_event(MODE_TIMEOUT, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
        send_event(make_event(MODE_RECV, KIND_CONFIRM, 1'b1, nx_addr, {1'b0, nx_port}));
        send_event(make_event(MODE_RECV, KIND_CONFIRM, 1'b0, nx_addr ^ 32'd1,
                              {1'b0, nx_port}));
        send_event(make_event(MODE_START, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
    endtask

    task automatic test_pass_random();
        set_peers(up_addr, 32'(up_port), 32'hFFFF_FFFF, 32'd25535, 32'd1);
        repeat (70) send_event(random_event());
        set_peers($urandom, any_port(), $urandom, 32'd0, 32'd1);
        repeat (70) send_event(random_event());
    endtask

    task automatic test_terminal();
        event_t ev;
        case ($urandom_range(0, 2))
            0: send_event(make_event(MODE_RECV, KIND_CONFIRM, 1'b0, nx_addr,
                                     {1'b0, nx_port}));
            1:
                while (ph_now != PCODE_FAIL)
                    send_event(make_event(MODE_TIMEOUT, KIND_CLOSE, 1'b0, 32'd0, 16'd0));
            default: send_event(make_event(MODE_SOCKERR, 3'($urandom_range(0, 7)), 1'b0,
                                           $urandom, 16'($urandom_range(0, 65535))));
        endcase
        // terminal: everything is ignored from here on
        repeat (12)
        begin
            ev = make_event(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                            1'($urandom_range(0, 1)), $urandom,
                            16'($urandom_range(0, 65535)));
            send_event(ev);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_ignored();
        test_request_retries();
        test_request_random();
        test_hold_replies();
        test_hold_random();
        test_pass_retries();
        test_pass_random();
        test_terminal();

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
